/* src/sipf_pkg.sv */
// shared types and constants for the screen idle power controller
`timescale 1ns / 1ps

package sipf_pkg;

  localparam int CountWidth = 16;
  localparam logic [31:0] MinTimeoutMs = 32'd5000;
  localparam logic [31:0] DefaultTimeoutMs = 32'd30000;
  localparam logic [31:0] MaxTimeoutMs = 32'd600000;
  localparam logic [31:0] ResetPreviewMs = 32'd3000;
  localparam logic [CountWidth-1:0] DepthMax = {CountWidth{1'b1}};

  typedef enum logic [1:0] {
    MODE_AWAKE   = 2'd0,
    MODE_PREVIEW = 2'd1,
    MODE_SLEEP   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    OP_INIT     = 4'd0,
    OP_TICK     = 4'd1,
    OP_INPUT    = 4'd2,
    OP_RELEASE  = 4'd3,
    OP_WAKE     = 4'd4,
    OP_CONFIRM  = 4'd5,
    OP_ACTIVITY = 4'd6,
    OP_MODAL    = 4'd7,
    OP_DISABLE  = 4'd8,
    OP_ENABLE   = 4'd9
  } op_t;

  typedef enum logic {
    REG_IDLE_TIMEOUT = 1'b0,
    REG_PREVIEW_DUR  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                  disp_off;
    logic                  disp_on;
    logic                  saver_on;
    logic                  saver_off;
    logic                  wake_flag;
    logic [1:0]            mode_now;
    logic [CountWidth-1:0] disable_count;
  } result_t;

  function automatic logic [31:0] clamp_timeout(input logic [31:0] t);
    logic [31:0] r;
    if (t < MinTimeoutMs) r = DefaultTimeoutMs;
    else if (t > MaxTimeoutMs) r = MaxTimeoutMs;
    else r = t;
    return r;
  endfunction

endpackage

/* src/sipf_cfg_regs.sv */
// configuration registers with timeout clamping on write
`timescale 1ns / 1ps

module sipf_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic [31:0] timeout_eff,
  output logic [31:0] preview_dur
);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_eff <= sipf_pkg::clamp_timeout(sipf_pkg::DefaultTimeoutMs);
      preview_dur <= sipf_pkg::ResetPreviewMs;
    end else if (cfg_we) begin
      case (sipf_pkg::reg_idx_t'(cfg_index))
        sipf_pkg::REG_IDLE_TIMEOUT: timeout_eff <= sipf_pkg::clamp_timeout(cfg_data);
        sipf_pkg::REG_PREVIEW_DUR:  preview_dur <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/sipf_core.sv */
// mode state machine, sleep-disable depth and activity timestamps
`timescale 1ns / 1ps

module sipf_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [3:0]          op,
  input  logic [31:0]         now_ms,
  input  logic [31:0]         timeout_eff,
  input  logic [31:0]         preview_dur,
  output sipf_pkg::result_t   res
);

  sipf_pkg::mode_t mode, mode_next;
  logic [sipf_pkg::CountWidth-1:0] depth, depth_next;
  logic [31:0] last_act, last_act_next;
  logic [31:0] prev_start, prev_start_next;

  logic [31:0] prev_elapsed, idle_elapsed;
  logic        prev_expired, idle_expired;

  // wrapping elapsed time
  assign prev_elapsed = now_ms - prev_start;
  assign idle_elapsed = now_ms - last_act;
  assign prev_expired = prev_elapsed >= preview_dur;
  assign idle_expired = idle_elapsed >= timeout_eff;

  // next state
  always_comb begin
    mode_next       = mode;
    depth_next      = depth;
    last_act_next   = last_act;
    prev_start_next = prev_start;
    case (op)
      sipf_pkg::OP_INIT: begin
        mode_next       = sipf_pkg::MODE_AWAKE;
        depth_next      = '0;
        last_act_next   = now_ms;
        prev_start_next = '0;
      end
      sipf_pkg::OP_TICK: begin
        if (depth == '0) begin
          if (mode == sipf_pkg::MODE_PREVIEW && prev_expired) begin
            mode_next       = sipf_pkg::MODE_SLEEP;
            prev_start_next = '0;
          end else if (mode == sipf_pkg::MODE_AWAKE && idle_expired) begin
            mode_next = sipf_pkg::MODE_SLEEP;
          end
        end
      end
      sipf_pkg::OP_INPUT, sipf_pkg::OP_WAKE: begin
        last_act_next = now_ms;
        if (mode == sipf_pkg::MODE_SLEEP) begin
          mode_next       = sipf_pkg::MODE_PREVIEW;
          prev_start_next = now_ms;
        end else if (mode == sipf_pkg::MODE_PREVIEW) begin
          prev_start_next = now_ms;
        end
      end
      sipf_pkg::OP_CONFIRM: begin
        last_act_next = now_ms;
        if (mode == sipf_pkg::MODE_SLEEP || mode == sipf_pkg::MODE_PREVIEW) begin
          mode_next       = sipf_pkg::MODE_AWAKE;
          prev_start_next = '0;
        end
      end
      sipf_pkg::OP_ACTIVITY: begin
        last_act_next = now_ms;
        if (mode == sipf_pkg::MODE_SLEEP) begin
          mode_next       = sipf_pkg::MODE_PREVIEW;
          prev_start_next = now_ms;
        end
      end
      sipf_pkg::OP_MODAL: begin
        last_act_next   = now_ms;
        mode_next       = sipf_pkg::MODE_AWAKE;
        prev_start_next = '0;
      end
      sipf_pkg::OP_DISABLE: begin
        if (depth != sipf_pkg::DepthMax) depth_next = depth + 1'b1;
        last_act_next = now_ms;
        if (mode != sipf_pkg::MODE_AWAKE) begin
          mode_next       = sipf_pkg::MODE_AWAKE;
          prev_start_next = '0;
        end
      end
      sipf_pkg::OP_ENABLE: begin
        if (depth != '0) depth_next = depth - 1'b1;
        last_act_next = now_ms;
      end
      default: ;
    endcase
  end

  // effect flags
  always_comb begin
    res               = '0;
    res.mode_now      = mode_next;
    res.disable_count = depth_next;
    case (op)
      sipf_pkg::OP_TICK: begin
        if (depth == '0) begin
          if (mode == sipf_pkg::MODE_PREVIEW && prev_expired) begin
            res.disp_off  = 1'b1;
            res.saver_off = 1'b1;
          end else if (mode == sipf_pkg::MODE_AWAKE && idle_expired) begin
            res.disp_off = 1'b1;
          end
        end
      end
      sipf_pkg::OP_INPUT, sipf_pkg::OP_WAKE, sipf_pkg::OP_ACTIVITY: begin
        if (mode == sipf_pkg::MODE_SLEEP) begin
          res.disp_on   = 1'b1;
          res.saver_on  = 1'b1;
          res.wake_flag = 1'b1;
        end
      end
      sipf_pkg::OP_CONFIRM, sipf_pkg::OP_DISABLE: begin
        if (mode != sipf_pkg::MODE_AWAKE) begin
          res.disp_on   = (mode == sipf_pkg::MODE_SLEEP);
          res.saver_off = 1'b1;
        end
      end
      sipf_pkg::OP_MODAL: begin
        res.disp_on   = (mode == sipf_pkg::MODE_SLEEP);
        res.saver_off = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sipf_pkg::MODE_AWAKE;
      depth      <= '0;
      last_act   <= '0;
      prev_start <= '0;
    end else if (step) begin
      mode       <= mode_next;
      depth      <= depth_next;
      last_act   <= last_act_next;
      prev_start <= prev_start_next;
    end
  end

  // state only moves when an item is processed
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(mode) && $stable(depth) && $stable(last_act))
    else $error("state changed without an item");

  // a blocked tick never changes the mode
  a_blocked_tick: assert property (@(posedge clk) disable iff (rst)
    step && op == sipf_pkg::OP_TICK && depth != '0 |=> $stable(mode))
    else $error("tick changed mode while sleep is disabled");

  // depth moves by at most one per item, init clears it outright
  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    step && op != sipf_pkg::OP_INIT |=> depth == $past(depth)
             || depth == $past(depth) + 1'b1 || depth == $past(depth) - 1'b1)
    else $error("depth jumped");

  // saver shown only on entry to preview, display off only into sleep
  a_saver_entry: assert property (@(posedge clk) disable iff (rst)
    step && res.saver_on |=> mode == sipf_pkg::MODE_PREVIEW && prev_start == $past(now_ms))
    else $error("saver shown without entering preview");

  a_sleep_entry: assert property (@(posedge clk) disable iff (rst)
    step && res.disp_off |=> mode == sipf_pkg::MODE_SLEEP && $past(depth) == '0)
    else $error("display slept without entering sleep");

endmodule

/* src/screen_idle_power_fsm.sv */
// top level of the screen idle power controller
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid/in_ready carries one event item (op, now_ms).
//   Output channel out_valid/out_ready carries one result item per event:
//   effect flags, mode_now and disable_count after the event.
//   Configuration: pulse cfg_we with cfg_index (0 idle timeout, 1 preview
//   duration) and cfg_data; the idle timeout is clamped when written.
//   Write configuration only while no event is in flight.
// Timing:
//   An item is taken into the input register; the mode logic (one 32-bit
//   subtract and compare per timer) then fills the result register and
//   raises out_valid once the result register is empty or being taken.
//   One item per cycle is sustained while out_ready stays high.
// Reset:
//   rst (synchronous) puts the block in awake mode with zero depth and zero
//   timestamps and restores the default timeout and preview duration.
// Back-pressure:
//   While out_ready is low the result register holds, the input register
//   fills, and in_ready then drops until the result is taken.

module screen_idle_power_fsm (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  op,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        disp_off,
  output logic        disp_on,
  output logic        saver_on,
  output logic        saver_off,
  output logic        wake_flag,
  output logic [1:0]  mode_now,
  output logic [15:0] disable_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic              s1_valid;
  logic [3:0]        s1_op;
  logic [31:0]       s1_now;
  logic              step;
  logic [31:0]       timeout_eff;
  logic [31:0]       preview_dur;
  sipf_pkg::result_t res;
  sipf_pkg::result_t res_q;

  assign step     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op  <= op;
      s1_now <= now_ms;
    end
  end

  sipf_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .timeout_eff (timeout_eff),
    .preview_dur (preview_dur)
  );

  sipf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .op          (s1_op),
    .now_ms      (s1_now),
    .timeout_eff (timeout_eff),
    .preview_dur (preview_dur),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign disp_off      = res_q.disp_off;
  assign disp_on       = res_q.disp_on;
  assign saver_on      = res_q.saver_on;
  assign saver_off     = res_q.saver_off;
  assign wake_flag     = res_q.wake_flag;
  assign mode_now      = res_q.mode_now;
  assign disable_count = res_q.disable_count;

endmodule

/* tb/testbench.sv */
// testbench for the screen idle power controller: directed and random event traffic
`timescale 1ns / 1ps

module testbench;

  localparam int ClkPeriod = 12;
  localparam int ResetCycles = 10;
  localparam int WatchdogLimit = 4000;
  localparam int LongHold = 48;
  localparam int SettleCycles = 4;
  localparam int NestDepth = 24;
  localparam logic [3:0] FirstUnusedOp = 4'd10;
  localparam logic [3:0] LastUnusedOp = 4'd15;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  op = 4'd0;
  logic [31:0] now_ms = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        disp_off;
  logic        disp_on;
  logic        saver_on;
  logic        saver_off;
  logic        wake_flag;
  logic [1:0]  mode_now;
  logic [15:0] disable_count;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = 32'd0;

  screen_idle_power_fsm dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .disp_off(disp_off),
    .disp_on(disp_on),
    .saver_on(saver_on),
    .saver_off(saver_off),
    .wake_flag(wake_flag),
    .mode_now(mode_now),
    .disable_count(disable_count),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted controller state
  sipf_pkg::mode_t pm_mode;
  logic [15:0]     pm_depth;
  logic [31:0]     pm_last_act;
  logic [31:0]     pm_preview_start;
  logic [31:0]     pm_timeout;
  logic [31:0]     pm_preview_len;

  sipf_pkg::result_t expected_fx[$];
  int              fail_count = 0;
  int              idle_cycles = 0;
  bit              jitter_on = 1'b0;
  bit              hold_req = 1'b0;
  logic [31:0]     stream_ms = 32'd0;

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  function automatic logic [31:0] effective_timeout(input logic [31:0] raw);
    if (raw < sipf_pkg::MinTimeoutMs) return sipf_pkg::DefaultTimeoutMs;
    if (raw > sipf_pkg::MaxTimeoutMs) return sipf_pkg::MaxTimeoutMs;
    return raw;
  endfunction

  function automatic void start_preview(inout sipf_pkg::result_t fx, input logic [31:0] t);
    pm_mode = sipf_pkg::MODE_PREVIEW;
    pm_preview_start = t;
    fx.disp_on = 1'b1;
    fx.saver_on = 1'b1;
    fx.wake_flag = 1'b1;
  endfunction

  function automatic void back_to_awake(inout sipf_pkg::result_t fx);
    fx.disp_on = (pm_mode == sipf_pkg::MODE_SLEEP);
    fx.saver_off = 1'b1;
    pm_mode = sipf_pkg::MODE_AWAKE;
    pm_preview_start = 32'd0;
  endfunction

  // advances the predicted state by one event and returns its effects
  function automatic sipf_pkg::result_t predict_event(input logic [3:0] code,
                                                      input logic [31:0] t);
    sipf_pkg::result_t fx;
    fx = '0;
    case (code)
      sipf_pkg::OP_INIT: begin
        pm_mode = sipf_pkg::MODE_AWAKE;
        pm_depth = '0;
        pm_last_act = t;
        pm_preview_start = 32'd0;
      end
      sipf_pkg::OP_TICK: begin
        if (pm_depth == 0) begin
          if (pm_mode == sipf_pkg::MODE_PREVIEW &&
              (t - pm_preview_start) >= pm_preview_len) begin
            pm_mode = sipf_pkg::MODE_SLEEP;
            pm_preview_start = 32'd0;
            fx.disp_off = 1'b1;
            fx.saver_off = 1'b1;
          end else if (pm_mode == sipf_pkg::MODE_AWAKE &&
                       (t - pm_last_act) >= pm_timeout) begin
            pm_mode = sipf_pkg::MODE_SLEEP;
            fx.disp_off = 1'b1;
          end
        end
      end
      sipf_pkg::OP_INPUT, sipf_pkg::OP_WAKE: begin
        pm_last_act = t;
        if (pm_mode == sipf_pkg::MODE_SLEEP) start_preview(fx, t);
        else if (pm_mode == sipf_pkg::MODE_PREVIEW) pm_preview_start = t;
      end
      sipf_pkg::OP_CONFIRM: begin
        pm_last_act = t;
        if (pm_mode != sipf_pkg::MODE_AWAKE) back_to_awake(fx);
      end
      sipf_pkg::OP_ACTIVITY: begin
        pm_last_act = t;
        if (pm_mode == sipf_pkg::MODE_SLEEP) start_preview(fx, t);
      end
      sipf_pkg::OP_MODAL: begin
        pm_last_act = t;
        back_to_awake(fx);
      end
      sipf_pkg::OP_DISABLE: begin
        if (pm_depth != sipf_pkg::DepthMax) pm_depth = pm_depth + 16'd1;
        pm_last_act = t;
        if (pm_mode != sipf_pkg::MODE_AWAKE) back_to_awake(fx);
      end
      sipf_pkg::OP_ENABLE: begin
        if (pm_depth != 0) pm_depth = pm_depth - 16'd1;
        pm_last_act = t;
      end
      default: ;
    endcase
    fx.mode_now = pm_mode;
    fx.disable_count = pm_depth;
    return fx;
  endfunction

  task automatic send_event(input logic [3:0] code, input logic [31:0] t);
    in_valid <= 1'b1;
    op <= code;
    now_ms <= t;
    do @(posedge clk); while (!in_ready);
    expected_fx.push_back(predict_event(code, t));
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // lets every outstanding result come back, then lets the channels settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_fx.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input sipf_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sipf_pkg::REG_IDLE_TIMEOUT) pm_timeout = effective_timeout(value);
    else pm_preview_len = value;
    @(posedge clk);
  endtask

  task automatic test_each_event();
    send_event(sipf_pkg::OP_TICK, 32'd29999);
    send_event(sipf_pkg::OP_TICK, 32'd30000);
    send_event(sipf_pkg::OP_RELEASE, 32'd30001);
    send_event(FirstUnusedOp, 32'd30002);
    send_event(LastUnusedOp, 32'd30003);
    send_event(sipf_pkg::OP_ACTIVITY, 32'd31000);
    send_event(sipf_pkg::OP_TICK, 32'd33999);
    send_event(sipf_pkg::OP_WAKE, 32'd33000);
    send_event(sipf_pkg::OP_TICK, 32'd36000);
    send_event(sipf_pkg::OP_INPUT, 32'd36100);
    send_event(sipf_pkg::OP_CONFIRM, 32'd36200);
    send_event(sipf_pkg::OP_TICK, 32'd36300);
    send_event(sipf_pkg::OP_MODAL, 32'd36400);
    send_event(sipf_pkg::OP_TICK, 32'd66400);
    send_event(sipf_pkg::OP_CONFIRM, 32'd66500);
    send_event(sipf_pkg::OP_TICK, 32'd96500);
    send_event(sipf_pkg::OP_MODAL, 32'd96600);
    send_event(sipf_pkg::OP_DISABLE, 32'd96700);
    send_event(sipf_pkg::OP_TICK, 32'hFFFF_0000);
    send_event(sipf_pkg::OP_ENABLE, 32'hFFFF_F000);
    send_event(sipf_pkg::OP_ENABLE, 32'hFFFF_F001);
    // elapsed time wraps through zero
    send_event(sipf_pkg::OP_TICK, 32'h0000_7001);
    send_event(sipf_pkg::OP_DISABLE, 32'h0000_7002);
    send_event(sipf_pkg::OP_INIT, 32'hFFFF_FFFF);
    send_event(sipf_pkg::OP_TICK, 32'h0000_752E);
    drain_results();
  endtask

  task automatic test_timeout_clamp();
    logic [31:0] raw [6];
    logic [31:0] t0;
    raw = '{32'd0, 32'd4999, 32'd5000, 32'd600000, 32'd600001, 32'hFFFF_FFFF};
    foreach (raw[i]) begin
      write_reg(sipf_pkg::REG_IDLE_TIMEOUT, raw[i]);
      t0 = $urandom();
      send_event(sipf_pkg::OP_INIT, t0);
      send_event(sipf_pkg::OP_TICK, t0 + pm_timeout - 32'd1);
      send_event(sipf_pkg::OP_TICK, t0 + pm_timeout);
      drain_results();
    end
  endtask

  task automatic test_preview_extremes();
    logic [31:0] len [4];
    logic [31:0] t0;
    logic [31:0] t1;
    len = '{32'd0, 32'd1, 32'hFFFF_FFFF, sipf_pkg::ResetPreviewMs};
    foreach (len[i]) begin
      write_reg(sipf_pkg::REG_PREVIEW_DUR, len[i]);
      t0 = $urandom();
      t1 = t0 + pm_timeout + 32'd5;
      send_event(sipf_pkg::OP_INIT, t0);
      send_event(sipf_pkg::OP_TICK, t0 + pm_timeout);
      send_event(sipf_pkg::OP_ACTIVITY, t1);
      send_event(sipf_pkg::OP_TICK, t1 + len[i] - 32'd1);
      send_event(sipf_pkg::OP_TICK, t1 + len[i]);
      drain_results();
    end
  endtask

  // nested disables block ticks, extra enables stop at zero
  task automatic test_depth_nesting();
    send_event(sipf_pkg::OP_INIT, 32'd100);
    for (int i = 0; i < NestDepth; i++) send_event(sipf_pkg::OP_DISABLE, 32'd200 + 32'(i));
    send_event(sipf_pkg::OP_TICK, 32'hFFFF_FFF0);
    for (int i = 0; i < NestDepth + 3; i++) send_event(sipf_pkg::OP_ENABLE, 32'd300);
    send_event(sipf_pkg::OP_DISABLE, 32'd350);
    send_event(sipf_pkg::OP_DISABLE, 32'd360);
    send_event(sipf_pkg::OP_INIT, 32'd400);
    drain_results();
  endtask

  task automatic test_backpressure();
    // receiver stops for a long stretch while items keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      stream_ms = stream_ms + $urandom_range(0, 20000);
      send_event(($urandom_range(0, 1) != 0) ? sipf_pkg::OP_TICK : sipf_pkg::OP_WAKE,
                 stream_ms);
    end
    drain_results();
  endtask

  task automatic test_pause_and_resume();
    for (int i = 0; i < 10; i++) begin
      stream_ms = stream_ms + $urandom_range(0, 15000);
      send_event(sipf_pkg::OP_TICK, stream_ms);
    end
    drain_results();
    for (int i = 0; i < 10; i++) begin
      stream_ms = stream_ms + $urandom_range(0, 15000);
      send_event(($urandom_range(0, 2) == 0) ? sipf_pkg::OP_ACTIVITY : sipf_pkg::OP_TICK,
                 stream_ms);
    end
    drain_results();
  endtask

  // mostly a plausible event stream with time moving forward, some noise
  task automatic run_traffic(input int count);
    int          pick;
    logic [3:0]  code;
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) code = sipf_pkg::OP_TICK;
      else if (pick < 45) code = sipf_pkg::OP_WAKE;
      else if (pick < 52) code = sipf_pkg::OP_INPUT;
      else if (pick < 60) code = sipf_pkg::OP_ACTIVITY;
      else if (pick < 68) code = sipf_pkg::OP_CONFIRM;
      else if (pick < 74) code = sipf_pkg::OP_MODAL;
      else if (pick < 82) code = sipf_pkg::OP_DISABLE;
      else if (pick < 92) code = sipf_pkg::OP_ENABLE;
      else if (pick < 95) code = sipf_pkg::OP_INIT;
      else if (pick < 97) code = sipf_pkg::OP_RELEASE;
      else code = 4'($urandom_range(FirstUnusedOp, LastUnusedOp));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        t = $urandom();
        stream_ms = t;
      end else if (pick < 15) begin
        // land on or just short of the running timer
        if (pm_mode == sipf_pkg::MODE_PREVIEW) t = pm_preview_start + pm_preview_len;
        else t = pm_last_act + pm_timeout;
        t = t - 32'($urandom_range(0, 1));
      end else begin
        stream_ms = stream_ms + $urandom_range(0, pm_timeout / 3);
        t = stream_ms;
      end
      send_event(code, t);
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_traffic(500);
    write_reg(sipf_pkg::REG_IDLE_TIMEOUT, sipf_pkg::MinTimeoutMs);
    write_reg(sipf_pkg::REG_PREVIEW_DUR, 32'd0);
    run_traffic(400);
    write_reg(sipf_pkg::REG_IDLE_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(sipf_pkg::REG_PREVIEW_DUR, 32'hFFFF_FFFF);
    run_traffic(300);
    write_reg(sipf_pkg::REG_IDLE_TIMEOUT, $urandom_range(0, 700000));
    write_reg(sipf_pkg::REG_PREVIEW_DUR, $urandom_range(0, 10000));
    run_traffic(400);
  endtask

  task automatic test_steady_stream();
    jitter_on = 1'b0;
    write_reg(sipf_pkg::REG_IDLE_TIMEOUT, sipf_pkg::MinTimeoutMs - 32'd1);
    write_reg(sipf_pkg::REG_PREVIEW_DUR, 32'd1);
    run_traffic(400);
  endtask

  // result side: random stall bursts and a long hold on request
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sipf_pkg::result_t want;
    sipf_pkg::result_t got;
    if (!rst && out_valid && out_ready) begin
      got.disp_off      = disp_off;
      got.disp_on       = disp_on;
      got.saver_on      = saver_on;
      got.saver_off     = saver_off;
      got.wake_flag     = wake_flag;
      got.mode_now      = mode_now;
      got.disable_count = disable_count;
      if (expected_fx.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result, expected none actual %h", $time, got);
      end else begin
        want = expected_fx.pop_front();
        if (want !== got) begin
          fail_count++;
          $display("%0t mismatch expected %h actual %h", $time, want, got);
        end
      end
    end
  end

  // ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    pm_mode = sipf_pkg::MODE_AWAKE;
    pm_depth = '0;
    pm_last_act = 32'd0;
    pm_preview_start = 32'd0;
    pm_timeout = effective_timeout(sipf_pkg::DefaultTimeoutMs);
    pm_preview_len = sipf_pkg::ResetPreviewMs;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    jitter_on = 1'b1;
    test_each_event();
    test_timeout_clamp();
    test_preview_extremes();
    test_depth_nesting();
    test_backpressure();
    test_pause_and_resume();
    test_random_traffic();
    test_steady_stream();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
